/* hw/rtl/ndem_pkg.sv */
// ----------------------------------------------------------------------------
// ndem_pkg
// Shared widths, register codes, reset values and types of the neighbor
// difference edge marker.
// ----------------------------------------------------------------------------
package ndem_pkg;

   localparam int PIXEL_W            = 24;
   localparam int IMAGE_WIDTH_W      = 12;
   localparam int IMAGE_HEIGHT_W     = 13;
   localparam int THRESHOLD_W        = 10;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 24;

   localparam int DEF_MAX_WIDTH      = 2048;
   localparam int DEF_MAX_HEIGHT     = 4096;

   localparam logic [IMAGE_WIDTH_W-1:0]  RST_IMAGE_WIDTH      = 12'd2048;
   localparam logic [IMAGE_HEIGHT_W-1:0] RST_IMAGE_HEIGHT     = 13'd2048;
   localparam logic [THRESHOLD_W-1:0]    RST_THRESHOLD_SUM    = 10'd7;
   localparam logic                      RST_USE_BORDER       = 1'b1;
   localparam logic [PIXEL_W-1:0]        RST_BORDER_COLOR     = 24'h000000;
   localparam logic                      RST_USE_BACKGROUND   = 1'b1;
   localparam logic [PIXEL_W-1:0]        RST_BACKGROUND_COLOR = 24'hFFFFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH      = 3'd0,
      REG_IMAGE_HEIGHT     = 3'd1,
      REG_THRESHOLD_SUM    = 3'd2,
      REG_USE_BORDER       = 3'd3,
      REG_BORDER_COLOR     = 3'd4,
      REG_USE_BACKGROUND   = 3'd5,
      REG_BACKGROUND_COLOR = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [IMAGE_WIDTH_W-1:0]  image_width;
      logic [IMAGE_HEIGHT_W-1:0] image_height;
      logic [THRESHOLD_W-1:0]    threshold_sum;
      logic                      use_border;
      logic [PIXEL_W-1:0]        border_color;
      logic                      use_background;
      logic [PIXEL_W-1:0]        background_color;
   } cfg_type;

   // raster position flags of one request, carried into the marking stage
   typedef struct packed {
      logic has_out;
      logic col_nonzero;
      logic row_end;
      logic last_image;
   } pos_type;

endpackage

/* hw/rtl/ndem_if.sv */
// ----------------------------------------------------------------------------
// ndem_if
// Valid/ready channels of the edge marker: pixel requests, marked pixel
// responses and register writes.
// ----------------------------------------------------------------------------
interface ndem_req_if;
   logic                         valid;
   logic                         ready;
   logic [ndem_pkg::PIXEL_W-1:0] in_pixel;

   modport source (output valid, output in_pixel, input ready);
   modport sink   (input valid, input in_pixel, output ready);
endinterface

interface ndem_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ndem_pkg::PIXEL_W-1:0] out_pixel;
   logic                         out_last_in_row;
   logic                         out_last_in_image;

   modport source (output valid, output out_pixel, output out_last_in_row,
                   output out_last_in_image, input ready);
   modport sink   (input valid, input out_pixel, input out_last_in_row,
                   input out_last_in_image, output ready);
endinterface

interface ndem_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ndem_pkg::CSR_INDEX_W-1:0] index;
   logic [ndem_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/ndem_regs.sv */
// ----------------------------------------------------------------------------
// ndem_regs
// Configuration register bank; writes are always taken, unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module ndem_regs (
   input  logic              clock,
   input  logic              reset,
   ndem_csr_if.sink          csr_ch,
   output ndem_pkg::cfg_type cfg
);

   ndem_pkg::cfg_type cfg_ff;
   ndem_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (ndem_pkg::reg_index_type'(csr_ch.index))
            ndem_pkg::REG_IMAGE_WIDTH: begin
               cfg_in.image_width = csr_ch.data[ndem_pkg::IMAGE_WIDTH_W-1:0];
            end
            ndem_pkg::REG_IMAGE_HEIGHT: begin
               cfg_in.image_height = csr_ch.data[ndem_pkg::IMAGE_HEIGHT_W-1:0];
            end
            ndem_pkg::REG_THRESHOLD_SUM: begin
               cfg_in.threshold_sum = csr_ch.data[ndem_pkg::THRESHOLD_W-1:0];
            end
            ndem_pkg::REG_USE_BORDER: begin
               cfg_in.use_border = csr_ch.data[0];
            end
            ndem_pkg::REG_BORDER_COLOR: begin
               cfg_in.border_color = csr_ch.data[ndem_pkg::PIXEL_W-1:0];
            end
            ndem_pkg::REG_USE_BACKGROUND: begin
               cfg_in.use_background = csr_ch.data[0];
            end
            ndem_pkg::REG_BACKGROUND_COLOR: begin
               cfg_in.background_color = csr_ch.data[ndem_pkg::PIXEL_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= ndem_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height     <= ndem_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.threshold_sum    <= ndem_pkg::RST_THRESHOLD_SUM;
         cfg_ff.use_border       <= ndem_pkg::RST_USE_BORDER;
         cfg_ff.border_color     <= ndem_pkg::RST_BORDER_COLOR;
         cfg_ff.use_background   <= ndem_pkg::RST_USE_BACKGROUND;
         cfg_ff.background_color <= ndem_pkg::RST_BACKGROUND_COLOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hw/rtl/ndem_line_buf.sv */
// ----------------------------------------------------------------------------
// ndem_line_buf
// Single-port line buffer, read-first: one access reads the pixel above and
// stores the new pixel at the same column.
// ----------------------------------------------------------------------------
module ndem_line_buf #(
   parameter int DEPTH = ndem_pkg::DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   input  logic [ndem_pkg::PIXEL_W-1:0] wr_data,
   output logic [ndem_pkg::PIXEL_W-1:0] rd_data
);

   logic [ndem_pkg::PIXEL_W-1:0] mem [DEPTH];
   logic [ndem_pkg::PIXEL_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   // old contents come out, new pixel goes in
   always_ff @(posedge clock) begin
      if (en) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

endmodule

/* hw/rtl/ndem_mark.sv */
// ----------------------------------------------------------------------------
// ndem_mark
// Edge decision and color substitution, with the response output register.
// ----------------------------------------------------------------------------
module ndem_mark (
   input  logic                         clock,
   input  logic                         reset,
   input  ndem_pkg::cfg_type            cfg,
   input  logic                         s1_valid,
   input  ndem_pkg::pos_type            s1_pos,
   input  logic [ndem_pkg::PIXEL_W-1:0] s1_pixel,
   input  logic [ndem_pkg::PIXEL_W-1:0] above,
   output logic                         advance,
   ndem_rsp_if.source                   rsp_ch
);

   function automatic logic [ndem_pkg::THRESHOLD_W-1:0] color_distance(
      input logic [ndem_pkg::PIXEL_W-1:0] a,
      input logic [ndem_pkg::PIXEL_W-1:0] b
   );
      logic [ndem_pkg::THRESHOLD_W-1:0] sum;
      logic [7:0]                       x;
      logic [7:0]                       y;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         x   = a[8*k +: 8];
         y   = b[8*k +: 8];
         sum = sum + {2'b00, ((x > y) ? (x - y) : (y - x))};
      end
      return sum;
   endfunction

   logic [ndem_pkg::PIXEL_W-1:0] left_ff;
   logic [ndem_pkg::PIXEL_W-1:0] left_in;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [ndem_pkg::PIXEL_W-1:0] out_pixel_ff;
   logic [ndem_pkg::PIXEL_W-1:0] out_pixel_in;
   logic                         out_row_ff;
   logic                         out_image_ff;
   logic                         edge_hit;

   assign advance = s1_valid && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      edge_hit = (color_distance(left_ff, above) > cfg.threshold_sum) ||
                 (color_distance(s1_pixel, above) > cfg.threshold_sum);
      out_pixel_in = above;
      if (s1_pos.col_nonzero) begin
         if (edge_hit) begin
            if (cfg.use_border) out_pixel_in = cfg.border_color;
         end else begin
            if (cfg.use_background) out_pixel_in = cfg.background_color;
         end
      end
      left_in = advance ? above : left_ff;
      if (advance && s1_pos.has_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_pos.has_out) begin
         out_pixel_ff <= out_pixel_in;
         out_row_ff   <= s1_pos.row_end;
         out_image_ff <= s1_pos.last_image;
      end
   end

   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.out_pixel         = out_pixel_ff;
   assign rsp_ch.out_last_in_row   = out_row_ff;
   assign rsp_ch.out_last_in_image = out_image_ff;

   a_image_end_is_row_end : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.out_last_in_image |-> rsp_ch.out_last_in_row)
      else $error("image end flagged without row end");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(out_pixel_ff))
      else $error("pending response overwritten");

   a_flags_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> $stable(out_row_ff) && $stable(out_image_ff))
      else $error("pending response flags changed");

endmodule

/* hw/rtl/neighbor_difference_edge_marker_top.sv */
// ----------------------------------------------------------------------------
// neighbor_difference_edge_marker_top
// Streaming edge marker over raster pixels with a one-row line buffer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  carries original pixels in raster order, one request per pixel.
//           After image_height rows send one extra row of zero pixels.
//   rsp_ch  carries each pixel of the row above the current request, marked
//           as border or background color if enabled (column 0 unchanged),
//           with row-end and image-end flags. Requests of the first row produce no response.
//   csr_ch  writes register index/data; always ready. Write only while idle.
// Throughput: one request per cycle while rsp_ch is not stalled, set by the
//   single line buffer port that reads the pixel above and stores the new one at once.
// Path: an accepted request is held in the read stage while the line buffer
//   reads the pixel above; the marking stage then writes the output register
//   that drives rsp_ch.valid.
// Reset: counters, valid flags and left-neighbor register clear; registers
//   take their defaults. The line buffer is not cleared: every entry is
//   written by row 0 before its contents are used.
// Stall: a held response keeps its value; one more request can sit in the
//   read stage, after which req_ch.ready drops until rsp_ch.ready returns.
// ----------------------------------------------------------------------------
module neighbor_difference_edge_marker_top #(
   parameter int MAX_WIDTH  = ndem_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ndem_pkg::DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   ndem_req_if.sink   req_ch,
   ndem_rsp_if.source rsp_ch,
   ndem_csr_if.sink   csr_ch
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W = (ndem_pkg::IMAGE_WIDTH_W > $clog2(MAX_WIDTH + 1)) ?
                           ndem_pkg::IMAGE_WIDTH_W : $clog2(MAX_WIDTH + 1);
   localparam int HCMP_W = (ndem_pkg::IMAGE_HEIGHT_W > ROW_W) ?
                           ndem_pkg::IMAGE_HEIGHT_W : ROW_W;

   ndem_pkg::cfg_type            cfg;
   logic                         accept;
   logic                         advance;
   logic [ndem_pkg::PIXEL_W-1:0] above;

   logic [COL_W-1:0]             col_ff;
   logic [COL_W-1:0]             col_in;
   logic [ROW_W-1:0]             row_ff;
   logic [ROW_W-1:0]             row_in;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   ndem_pkg::pos_type            s1_pos_ff;
   ndem_pkg::pos_type            pos_in;
   logic [ndem_pkg::PIXEL_W-1:0] s1_pixel_ff;

   logic [WCMP_W-1:0]            width_ext;
   logic [WCMP_W-1:0]            width_eff;
   logic [WCMP_W-1:0]            col_next;
   logic [HCMP_W-1:0]            height_ext;
   logic [HCMP_W-1:0]            height_eff;
   logic                         pad_row;

   ndem_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // take a request whenever the read stage is empty or moves on
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   // clamp width and height into their legal ranges
   always_comb begin
      width_ext  = WCMP_W'(cfg.image_width);
      height_ext = HCMP_W'(cfg.image_height);
      if (width_ext == '0) begin
         width_eff = WCMP_W'(1);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         width_eff = WCMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      if (height_ext == '0) begin
         height_eff = HCMP_W'(1);
      end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
         height_eff = HCMP_W'(MAX_HEIGHT);
      end else begin
         height_eff = height_ext;
      end
   end

   // raster position of the request now on the input
   always_comb begin
      col_next           = WCMP_W'(col_ff) + WCMP_W'(1);
      pad_row            = HCMP_W'(row_ff) >= height_eff;
      pos_in.row_end     = col_next >= width_eff;
      pos_in.has_out     = row_ff != '0;
      pos_in.col_nonzero = col_ff != '0;
      pos_in.last_image  = pos_in.row_end && pad_row;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (pos_in.row_end) begin
            col_in = '0;
            row_in = pad_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // hold the request beside the line buffer read data
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff   <= pos_in;
         s1_pixel_ff <= req_ch.in_pixel;
      end
   end

   ndem_line_buf #(
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .en      (accept),
      .addr    (col_ff),
      .wr_data (req_ch.in_pixel),
      .rd_data (above)
   );

   ndem_mark u_mark (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .s1_valid (s1_valid_ff),
      .s1_pos   (s1_pos_ff),
      .s1_pixel (s1_pixel_ff),
      .above    (above),
      .advance  (advance),
      .rsp_ch   (rsp_ch)
   );

   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request missing from read stage");

   a_row_end_wraps : assert property (@(posedge clock) disable iff (reset)
      accept && pos_in.row_end |=> col_ff == '0)
      else $error("column counter did not wrap at row end");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_pixel_ff))
      else $error("stalled read stage lost its request");

   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      accept |-> WCMP_W'(col_ff) < width_eff || WCMP_W'(col_ff) >= width_eff)
      else $error("column counter undefined");

endmodule
